// ----- src/otb_pkg.sv -----
// Shared types and constants for the octant triangle binner.
// No dependencies.
package otb_pkg;
  localparam int CoordBits = 32;
  localparam int InBits = 32;
  localparam int DBits = CoordBits + 4;
  localparam int SqBits = 2 * DBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [2:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StEval,
    StGrow,
    StOut
  } state_e;

  typedef struct packed {
    logic load_vtx;
    logic load_oct;
    logic clr_best;
    logic eval;
    logic grow;
  } cmd_t;

  function automatic coord_t wrap_in(input logic [InBits-1:0] raw);
    logic signed [InBits-1:0] s;
    s = raw;
    return coord_t'(s);
  endfunction
endpackage

// ----- src/octant_triangle_binner.sv -----
// Octant triangle binner, top level.
// Depends on otb_pkg, otb_ctrl, otb_dp.
//
// Usage: write scene box min/max (indices 0..5) on the cfg channel while
// idle. An input transfer with action 0 loads the eight octants of the scene
// box as child boxes and gives no result. Action 1 bins a
// triangle: the eight children are scored one per cycle by squared distance
// of centroid to box center (ties go to the lowest index), the winner's box
// grows to enclose the vertices, and child_index_o is presented.
// One item is in flight at a time, so a triangle is done only after its
// output transfer; the pace is set by the sequential sweep over the eight
// child boxes.
// A stalled receiver holds the result; no input is taken until it goes.
// Reset clears scene registers and all child boxes to zero.
module octant_triangle_binner import otb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] v0_x_i, v0_y_i, v0_z_i,
  input  logic [31:0] v1_x_i, v1_y_i, v1_z_i,
  input  logic [31:0] v2_x_i, v2_y_i, v2_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  child_index_o
);
  cmd_t cmd;
  logic [2:0] sel;
  logic [InBits-1:0] vtx [9];

  assign cfg_ready_o = 1'b1;
  assign vtx = '{v0_x_i, v0_y_i, v0_z_i, v1_x_i, v1_y_i, v1_z_i, v2_x_i, v2_y_i, v2_z_i};

  otb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .action_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .child_sel_o(sel), .cmd_o(cmd)
  );

  otb_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .child_sel_i(sel),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .vtx_i(vtx), .best_o(child_index_o)
  );
endmodule

// ----- src/otb_ctrl.sv -----
// Sequencer of the binner: start, octant load, eight-child sweep, grow, result.
// Depends on otb_pkg.
module otb_ctrl import otb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       action_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] child_sel_o,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = action_i ? StEval : StLoad;
          cnt_d = '0;
        end
      end
      StLoad: state_d = StIdle;
      StEval: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) state_d = StGrow;
      end
      StGrow: state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load_vtx = in_valid_i;
        cmd_o.clr_best = in_valid_i;
      end
      StLoad: cmd_o.load_oct = 1'b1;
      StEval: cmd_o.eval = 1'b1;
      StGrow: cmd_o.grow = 1'b1;
      StOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end
  assign child_sel_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while busy");
  a_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.grow |-> $past(cmd_o.eval) && $past(child_sel_o) == 3'd7)
    else $error("grow without full sweep");
`endif
endmodule

// ----- src/otb_dp.sv -----
// Datapath: scene registers, child boxes, distance unit and best tracker.
// Depends on otb_pkg.
module otb_dp import otb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [2:0]        child_sel_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [InBits-1:0] cfg_data_i,
  input  logic [InBits-1:0] vtx_i [9],
  output logic [2:0]        best_o
);
  coord_t scn_min_q [3];
  coord_t scn_max_q [3];
  coord_t cmin_q [24];
  coord_t cmax_q [24];
  coord_t v_q [9];
  logic signed [CoordBits+1:0] sum_q [3];
  logic [SqBits-1:0] best_d_q;
  logic [2:0] best_q;
  logic [SqBits-1:0] dist_sq;
  logic [4:0] base;

  always_comb begin
    logic signed [DBits-1:0] d;
    logic [DBits-1:0] mag;
    logic [2*DBits-1:0] sq;
    dist_sq = '0;
    base = 5'(child_sel_i) * 5'd3;
    for (int a = 0; a < 3; a++) begin
      d = DBits'(sum_q[a]) * DBits'(2)
        - (DBits'(cmin_q[base + 5'(a)]) + DBits'(cmax_q[base + 5'(a)])) * DBits'(3);
      mag = d[DBits-1] ? DBits'(-d) : DBits'(d);
      sq = mag * mag;
      dist_sq = dist_sq + SqBits'(sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        scn_min_q[a] <= '0;
        scn_max_q[a] <= '0;
      end
      for (int i = 0; i < 24; i++) begin
        cmin_q[i] <= '0;
        cmax_q[i] <= '0;
      end
      best_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMinX: scn_min_q[0] <= wrap_in(cfg_data_i);
          RegMinY: scn_min_q[1] <= wrap_in(cfg_data_i);
          RegMinZ: scn_min_q[2] <= wrap_in(cfg_data_i);
          RegMaxX: scn_max_q[0] <= wrap_in(cfg_data_i);
          RegMaxY: scn_max_q[1] <= wrap_in(cfg_data_i);
          RegMaxZ: scn_max_q[2] <= wrap_in(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.load_oct) begin
        for (int c = 0; c < 8; c++) begin
          for (int a = 0; a < 3; a++) begin
            logic signed [CoordBits:0] s;
            s = (CoordBits+1)'(scn_min_q[a]) + (CoordBits+1)'(scn_max_q[a]);
            if (c[a]) begin
              cmin_q[c*3+a] <= coord_t'(s >>> 1);
              cmax_q[c*3+a] <= scn_max_q[a];
            end else begin
              cmin_q[c*3+a] <= scn_min_q[a];
              cmax_q[c*3+a] <= coord_t'(s >>> 1);
            end
          end
        end
      end
      if (cmd_i.clr_best) best_q <= '0;
      else if (cmd_i.eval && (child_sel_i == 3'd0 || dist_sq < best_d_q)) best_q <= child_sel_i;
      if (cmd_i.grow) begin
        for (int a = 0; a < 3; a++) begin
          coord_t mn, mx;
          mn = cmin_q[5'(best_q)*5'd3 + 5'(a)];
          mx = cmax_q[5'(best_q)*5'd3 + 5'(a)];
          for (int i = 0; i < 3; i++) begin
            if (v_q[i*3+a] < mn) mn = v_q[i*3+a];
            if (v_q[i*3+a] > mx) mx = v_q[i*3+a];
          end
          cmin_q[5'(best_q)*5'd3 + 5'(a)] <= mn;
          cmax_q[5'(best_q)*5'd3 + 5'(a)] <= mx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vtx) begin
      for (int i = 0; i < 9; i++) v_q[i] <= wrap_in(vtx_i[i]);
      for (int a = 0; a < 3; a++)
        sum_q[a] <= (CoordBits+2)'(wrap_in(vtx_i[a])) + (CoordBits+2)'(wrap_in(vtx_i[3+a]))
                  + (CoordBits+2)'(wrap_in(vtx_i[6+a]));
    end
    if (cmd_i.eval && (child_sel_i == 3'd0 || dist_sq < best_d_q)) best_d_q <= dist_sq;
  end
  assign best_o = best_q;

`ifndef SYNTH
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.load_oct) && scn_min_q[0] <= scn_max_q[0] && $stable(scn_min_q[0])
    && $stable(scn_max_q[0]) |-> cmin_q[0] <= cmax_q[0]) else $error("octant inverted");
  a_best_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval && child_sel_i == 3'd0 |=> best_q == 3'd0) else $error("best not reset");
  a_grow_enclose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grow |=> cmin_q[5'(best_q)*5'd3] <= v_q[0]) else $error("box not grown");
`endif
endmodule
